### hdl/bounded_sorted_priority_queue_defines.svh
// Assertion macros used by the priority queue top module.
// Expect clk_i and rst_ni in the scope of use.
`ifndef BOUNDED_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define BOUNDED_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// checked only while out of reset
`define BSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BSQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/bsq_pkg.sv
// Package for the bounded sorted priority queue: sizes, codes and types.
// No dependencies.
`timescale 1ns / 1ps

package bsq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W = 5;
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_PULL   = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pull;
  } cell_ctrl_t;

endpackage

### hdl/bsq_in_if.sv
// Input channel of the priority queue: valid/ready plus operation payload.
// No dependencies.
`timescale 1ns / 1ps

interface bsq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] item_value;
  logic signed [15:0] item_priority;

  modport source (output valid, opcode, item_value, item_priority, input ready);
  modport sink (input valid, opcode, item_value, item_priority, output ready);
endinterface

### hdl/bsq_out_if.sv
// Result channel of the priority queue: valid/ready plus result payload.
// No dependencies.
`timescale 1ns / 1ps

interface bsq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] head_value;
  logic [1:0]         status;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, head_value, status, is_empty, is_full, input ready);
  modport sink (input valid, head_value, status, is_empty, is_full, output ready);
endinterface

### hdl/bsq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with a new one,
// and takes the new entry or a neighbor's entry. Depends on bsq_pkg.
`timescale 1ns / 1ps

module bsq_cell (
  input  logic               clk_i,
  input  bsq_pkg::cell_ctrl_t ctrl_i,
  input  logic               in_use_i,
  input  bsq_pkg::entry_t    new_i,
  input  bsq_pkg::entry_t    left_i,
  input  logic               left_ge_i,
  input  bsq_pkg::entry_t    right_i,
  output bsq_pkg::entry_t    entry_o,
  output logic               ge_o
);

  bsq_pkg::entry_t entry_q, entry_d;

  // stored entry stays ahead of the new one (ties keep arrival order)
  assign ge_o = in_use_i && ($signed(entry_q.prio) >= $signed(new_i.prio));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!ge_o) begin
        entry_d = left_ge_i ? new_i : left_i;
      end
    end else if (ctrl_i.pull) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### hdl/bsq_cfg.sv
// APB-style register block holding the capacity register.
// Depends on bsq_pkg.
`timescale 1ns / 1ps

module bsq_cfg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output logic [bsq_pkg::CAP_W-1:0] capacity_o
);

  logic [bsq_pkg::CAP_W-1:0] capacity_q, capacity_d;
  logic                      sel_cap;

  assign sel_cap = (paddr[2] == bsq_pkg::REG_CAPACITY);
  assign pready  = 1'b1;

  always_comb begin
    capacity_d = capacity_q;
    if (psel && penable && pwrite && pready && sel_cap) begin
      capacity_d = pwdata[bsq_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= bsq_pkg::CAP_RESET;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  assign prdata = sel_cap ? {{(32 - bsq_pkg::CAP_W){1'b0}}, capacity_q} : 32'd0;
  assign capacity_o = capacity_q;

endmodule

### hdl/bounded_sorted_priority_queue.sv
// Bounded priority queue kept sorted, highest priority first, in a row of
// compare-and-shift cells; equal priorities leave in arrival order. Each
// operation (insert, pull, peek) yields one result from a result register;
// a new operation is taken every cycle while results are drained, as all
// cells compare against the new entry and shift in parallel.
// Capacity is set over the APB port (word 0) and saturates at the built depth.
// Depends on bsq_pkg, bsq_in_if, bsq_out_if, bsq_cell, bsq_cfg and the defines.
`timescale 1ns / 1ps
`include "bounded_sorted_priority_queue_defines.svh"

module bounded_sorted_priority_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsq_in_if.sink      in_i,
  bsq_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned D  = bsq_pkg::DEPTH;
  localparam int unsigned OW = bsq_pkg::OCC_W;
  localparam int unsigned CW = bsq_pkg::CMP_W;

  logic [bsq_pkg::CAP_W-1:0] capacity;
  logic [OW-1:0]             occ_q, occ_d;
  logic                      out_valid_q, out_valid_d;
  logic [1:0]                status_q, status_d;
  logic                      accept, full, empty, do_ins, do_pull;
  logic [CW-1:0]             cap_w, eff_cap, occ_w;
  bsq_pkg::cell_ctrl_t       ctrl;
  bsq_pkg::entry_t           new_entry;
  bsq_pkg::entry_t           cell_q [D];
  logic                      ge [D];

  bsq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  assign cap_w   = CW'(capacity);
  assign eff_cap = (cap_w > CW'(D)) ? CW'(D) : cap_w;
  assign occ_w   = CW'(occ_q);
  assign full    = (occ_w >= eff_cap);
  assign empty   = (occ_q == '0);

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign do_ins     = accept && (in_i.opcode == bsq_pkg::OP_INSERT) && !full;
  assign do_pull    = accept && (in_i.opcode == bsq_pkg::OP_PULL) && !empty;
  assign ctrl       = '{ins: do_ins, pull: do_pull};
  assign new_entry  = '{value: in_i.item_value, prio: in_i.item_priority};

  for (genvar k = 0; k < D; k++) begin : g_cell
    bsq_pkg::entry_t left, right;
    logic            left_ge;
    if (k == 0) begin : g_first
      assign left    = new_entry;
      assign left_ge = 1'b1;
    end else begin : g_mid
      assign left    = cell_q[k-1];
      assign left_ge = ge[k-1];
    end
    if (k == D - 1) begin : g_last
      assign right = cell_q[k];
    end else begin : g_inner
      assign right = cell_q[k+1];
    end
    bsq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .in_use_i  (occ_q > OW'(k)),
      .new_i     (new_entry),
      .left_i    (left),
      .left_ge_i (left_ge),
      .right_i   (right),
      .entry_o   (cell_q[k]),
      .ge_o      (ge[k])
    );
  end

  always_comb begin
    occ_d       = occ_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = bsq_pkg::ST_DONE;
      case (in_i.opcode)
        bsq_pkg::OP_INSERT: begin
          if (full) begin
            status_d = bsq_pkg::ST_FULL;
          end else begin
            occ_d = occ_q + OW'(1);
          end
        end
        bsq_pkg::OP_PULL: begin
          if (empty) begin
            status_d = bsq_pkg::ST_EMPTY;
          end else begin
            occ_d = occ_q - OW'(1);
          end
        end
        default: begin
          status_d = bsq_pkg::ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= bsq_pkg::ST_DONE;
    end else begin
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  // state only moves on a transfer, so the result reads the stored queue
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.head_value = empty ? 32'sd0 : cell_q[0].value;
  assign out_o.is_empty   = empty;
  assign out_o.is_full    = full;

  `BSQ_ASSERT_ALWAYS(a_occ_bound, (occ_q <= OW'(D)), "occupancy above depth")
  `BSQ_ASSERT(a_refused_hold, (accept && status_d != bsq_pkg::ST_DONE) |=> $stable(occ_q), "refused op changed occupancy")
  `BSQ_ASSERT(a_pull_dec, do_pull |=> (occ_q == $past(occ_q) - OW'(1)), "pull did not decrement")
  `BSQ_ASSERT(a_sorted, (occ_q >= OW'(2)) |-> ($signed(cell_q[0].prio) >= $signed(cell_q[1].prio)), "head out of order")

endmodule
